FILE: rtl/tsc_pkg.sv
// Shared types and constants for the two-stage sleep controller.
// No dependencies; imported by the interfaces and every module of the block.
package tsc_pkg;

  localparam int unsigned LIMIT_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned COORD_W   = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_INACTIVITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_WAIT  = 2'd2;

  localparam logic [LIMIT_W-1:0] INACTIVITY_RST = 32'd60000;
  localparam logic [LIMIT_W-1:0] LIGHT_RST      = 32'd300000;
  localparam logic [LIMIT_W-1:0] LINK_WAIT_RST  = 32'd15000;

  localparam logic [1:0] MODE_TICK     = 2'd0;
  localparam logic [1:0] MODE_ACTIVITY = 2'd1;
  localparam logic [1:0] MODE_TOUCH    = 2'd2;
  localparam logic [1:0] MODE_SPURIOUS = 2'd3;

  localparam logic [1:0] PH_ACTIVE = 2'd0;
  localparam logic [1:0] PH_LIGHT  = 2'd1;
  localparam logic [1:0] PH_DEEP   = 2'd2;
  localparam logic [1:0] PH_OFF    = 2'd3;

  typedef enum logic [3:0] {
    ST_ACTIVE = 4'b0001,
    ST_LIGHT  = 4'b0010,
    ST_DEEP   = 4'b0100,
    ST_OFF    = 4'b1000
  } state_e;

  typedef struct packed {
    logic [1:0]         phase;
    logic               sleep_entered;
    logic               touch_resumed;
    logic [COORD_W-1:0] tap_x;
    logic [COORD_W-1:0] tap_y;
    logic               power_off;
  } result_t;

endpackage

FILE: rtl/tsc_if.sv
// Handshake channels of the sleep controller: item in, result out.
// Depends on tsc_pkg.
interface tsc_in_if;
  import tsc_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic               link_up;
  logic               hold_awake;
  logic [COORD_W-1:0] touch_x;
  logic [COORD_W-1:0] touch_y;
  modport source (output valid, mode, link_up, hold_awake, touch_x, touch_y, input ready);
  modport sink   (input valid, mode, link_up, hold_awake, touch_x, touch_y, output ready);
endinterface

interface tsc_out_if;
  import tsc_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         phase;
  logic               sleep_entered;
  logic               touch_resumed;
  logic [COORD_W-1:0] tap_x;
  logic [COORD_W-1:0] tap_y;
  logic               power_off;
  modport source (output valid, phase, sleep_entered, touch_resumed, tap_x, tap_y, power_off,
                  input ready);
  modport sink   (input valid, phase, sleep_entered, touch_resumed, tap_x, tap_y, power_off,
                  output ready);
endinterface

FILE: rtl/two_stage_sleep_controller.sv
// Top level of the two-stage sleep controller: limit registers, sequencer state,
// result register. Depends on tsc_pkg, tsc_if and tsc_eval.
//
// One transaction per clock unless the output stalls: an item (tick, activity,
// touch wakeup or spurious wakeup) updates the sequencer state and the result
// register at the edge it is accepted. The single output register sets the
// rate: in_i.ready is high when it is empty or taken in the same cycle, so items
// run at one per cycle unless out_o stalls. The user must write limits through
// cfg_we_i/cfg_idx_i/cfg_wdata_i only while no transaction is in flight; the
// block does not enforce this. Indexes beyond the third register are ignored.
module two_stage_sleep_controller #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tsc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tsc_pkg::LIMIT_W-1:0]   cfg_wdata_i,
  tsc_in_if.sink                        in_i,
  tsc_out_if.source                     out_o
);
  import tsc_pkg::*;

  logic [LIMIT_W-1:0]    inact_lim_q, light_lim_q, link_lim_q;
  state_e                state_q, state_d;
  logic [TIME_WIDTH-1:0] now_q, now_d;
  logic [TIME_WIDTH-1:0] last_act_q, last_act_d;
  logic [TIME_WIDTH-1:0] light_entry_q, light_entry_d;
  logic                  entry_valid_q, entry_valid_d;
  logic [TIME_WIDTH-1:0] deep_since_q, deep_since_d;
  result_t               res_d, res_q;
  logic                  out_valid_q;
  logic                  accept;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inact_lim_q <= INACTIVITY_RST;
      light_lim_q <= LIGHT_RST;
      link_lim_q  <= LINK_WAIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INACTIVITY: inact_lim_q <= cfg_wdata_i;
        CFG_LIGHT:      light_lim_q <= cfg_wdata_i;
        CFG_LINK_WAIT:  link_lim_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  tsc_eval #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_eval (
    .mode_i        (in_i.mode),
    .link_up_i     (in_i.link_up),
    .hold_awake_i  (in_i.hold_awake),
    .touch_x_i     (in_i.touch_x),
    .touch_y_i     (in_i.touch_y),
    .inact_lim_i   (inact_lim_q),
    .light_lim_i   (light_lim_q),
    .link_lim_i    (link_lim_q),
    .state_i       (state_q),
    .now_i         (now_q),
    .last_act_i    (last_act_q),
    .light_entry_i (light_entry_q),
    .entry_valid_i (entry_valid_q),
    .deep_since_i  (deep_since_q),
    .state_o       (state_d),
    .now_o         (now_d),
    .last_act_o    (last_act_d),
    .light_entry_o (light_entry_d),
    .entry_valid_o (entry_valid_d),
    .deep_since_o  (deep_since_d),
    .res_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_ACTIVE;
      now_q         <= '0;
      last_act_q    <= '0;
      light_entry_q <= '0;
      entry_valid_q <= 1'b0;
      deep_since_q  <= '0;
    end else if (accept) begin
      state_q       <= state_d;
      now_q         <= now_d;
      last_act_q    <= last_act_d;
      light_entry_q <= light_entry_d;
      entry_valid_q <= entry_valid_d;
      deep_since_q  <= deep_since_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) res_q <= res_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.phase         = res_q.phase;
  assign out_o.sleep_entered = res_q.sleep_entered;
  assign out_o.touch_resumed = res_q.touch_resumed;
  assign out_o.tap_x         = res_q.tap_x;
  assign out_o.tap_y         = res_q.tap_y;
  assign out_o.power_off     = res_q.power_off;

endmodule

FILE: rtl/tsc_eval.sv
// Next-state and result logic for one transaction of the sleep controller.
// Purely combinational; depends on tsc_pkg.
module tsc_eval #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic [1:0]                  mode_i,
  input  logic                        link_up_i,
  input  logic                        hold_awake_i,
  input  logic [tsc_pkg::COORD_W-1:0] touch_x_i,
  input  logic [tsc_pkg::COORD_W-1:0] touch_y_i,
  input  logic [tsc_pkg::LIMIT_W-1:0] inact_lim_i,
  input  logic [tsc_pkg::LIMIT_W-1:0] light_lim_i,
  input  logic [tsc_pkg::LIMIT_W-1:0] link_lim_i,
  input  tsc_pkg::state_e             state_i,
  input  logic [TIME_WIDTH-1:0]       now_i,
  input  logic [TIME_WIDTH-1:0]       last_act_i,
  input  logic [TIME_WIDTH-1:0]       light_entry_i,
  input  logic                        entry_valid_i,
  input  logic [TIME_WIDTH-1:0]       deep_since_i,
  output tsc_pkg::state_e             state_o,
  output logic [TIME_WIDTH-1:0]       now_o,
  output logic [TIME_WIDTH-1:0]       last_act_o,
  output logic [TIME_WIDTH-1:0]       light_entry_o,
  output logic                        entry_valid_o,
  output logic [TIME_WIDTH-1:0]       deep_since_o,
  output tsc_pkg::result_t            res_o
);
  import tsc_pkg::*;

  logic [TIME_WIDTH-1:0] now_inc;
  logic [TIME_WIDTH-1:0] entry_eff;
  logic [TIME_WIDTH-1:0] since_act;
  logic [TIME_WIDTH-1:0] since_light;
  logic [TIME_WIDTH-1:0] since_deep;
  logic                  act_exp;
  logic                  light_exp;
  logic                  link_exp;

  assign now_inc     = now_i + TIME_WIDTH'(1);
  assign entry_eff   = entry_valid_i ? light_entry_i : now_inc;
  assign since_act   = now_inc - last_act_i;
  assign since_light = now_inc - entry_eff;
  assign since_deep  = now_inc - deep_since_i;
  assign act_exp     = LIMIT_W'(since_act) >= inact_lim_i;
  assign light_exp   = LIMIT_W'(since_light) >= light_lim_i;
  assign link_exp    = LIMIT_W'(since_deep) >= link_lim_i;

  always_comb begin
    state_o       = state_i;
    now_o         = now_i;
    last_act_o    = last_act_i;
    light_entry_o = light_entry_i;
    entry_valid_o = entry_valid_i;
    deep_since_o  = deep_since_i;
    res_o         = '0;
    unique case (mode_i)
      MODE_TICK: begin
        now_o = now_inc;
        unique case (state_i)
          ST_OFF: ;
          ST_DEEP: begin
            if (link_up_i || link_exp) begin
              state_o         = ST_OFF;
              res_o.power_off = 1'b1;
            end
          end
          default: begin
            if (!hold_awake_i && act_exp) begin
              if (!entry_valid_i) begin
                light_entry_o       = now_inc;
                entry_valid_o       = 1'b1;
                res_o.sleep_entered = 1'b1;
              end
              state_o = ST_LIGHT;
              if (light_exp) begin
                state_o       = ST_DEEP;
                deep_since_o  = now_inc;
                entry_valid_o = 1'b0;
              end
            end
          end
        endcase
      end
      MODE_ACTIVITY: begin
        if (state_i != ST_OFF) begin
          last_act_o = now_i;
          if (state_i == ST_LIGHT) state_o = ST_ACTIVE;
        end
      end
      MODE_TOUCH: begin
        if (state_i == ST_LIGHT) begin
          state_o             = ST_ACTIVE;
          last_act_o          = now_i;
          entry_valid_o       = 1'b0;
          res_o.touch_resumed = 1'b1;
          res_o.tap_x         = touch_x_i;
          res_o.tap_y         = touch_y_i;
        end
      end
      MODE_SPURIOUS: ;
      default: ;
    endcase
    unique case (state_o)
      ST_ACTIVE: res_o.phase = PH_ACTIVE;
      ST_LIGHT:  res_o.phase = PH_LIGHT;
      ST_DEEP:   res_o.phase = PH_DEEP;
      ST_OFF:    res_o.phase = PH_OFF;
      default:   res_o.phase = PH_ACTIVE;
    endcase
  end

endmodule
